### hw/rtl/rsi_pkg.sv
// rsi_pkg: shared constants, codes and controller/datapath handshake types
// for the streaming Wilder RSI block. No dependencies.
`timescale 1ns / 1ps

package rsi_pkg;

	localparam int PRICE_BITS_DEF = 32;
	localparam int EXTRA_BITS_DEF = 16;

	localparam int PERIOD_W = 8;
	localparam int CNT_W    = 9;
	localparam int RSI_W    = 23;
	localparam int RSI_FRAC = 16;
	localparam int RSI_SCALE = 100;
	// width of the multiplier 100 in 100*g, before it is shifted up by the fraction bits
	localparam int SCALE_W  = 7;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 8'd14;
	localparam logic [CNT_W-1:0]    SMOOTH_MARK    = 9'd256;
	localparam logic [RSI_W-1:0]    RSI_FULL_SCALE = 23'd6553600;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_CHECK,
		ST_FINISH
	} ctrl_state_t;

	typedef enum logic [2:0] {
		OP_SEED_GAIN,
		OP_SEED_LOSS,
		OP_WILD_GAIN,
		OP_WILD_LOSS,
		OP_RATIO
	} div_op_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_FULL,
		RES_RATIO
	} res_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     eval;
		logic     mul;
		logic     div_start;
		logic     div_write;
		logic     load_out;
		div_op_t  op;
		res_sel_t res_sel;
	} rsi_cmd_t;

	typedef struct packed {
		logic first;
		logic seeding;
		logic seed_full;
		logic loss_zero;
		logic div_done;
		logic out_free;
	} rsi_sts_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

### hw/rtl/rsi_if.sv
// rsi_if: valid/ready channel interfaces for price samples, rsi results and
// the period register write. Depends on rsi_pkg.
`timescale 1ns / 1ps

interface rsi_in_if #(parameter int PRICE_BITS = 32) ();
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] price;
	logic                  restart;

	modport source (output valid, output price, output restart, input ready);
	modport sink (input valid, input price, input restart, output ready);
endinterface

interface rsi_out_if import rsi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RSI_W-1:0] rsi_value;
	logic             ready_res;

	modport source (output valid, output rsi_value, output ready_res, input ready);
	modport sink (input valid, input rsi_value, input ready_res, output ready);
endinterface

interface rsi_cfg_if import rsi_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PERIOD_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/rsi_wilder_stream.sv
// rsi_wilder_stream: top level of the streaming Wilder RSI block.
// Depends on rsi_pkg, rsi_if, rsi_ctrl, rsi_dp and rsi_div.
`timescale 1ns / 1ps

// One price request in, one result out. A restart, the first sample, or a
// sample while the window is still filling goes from accept through the eval
// state to the finish state, which waits for a free output register. The
// request that completes the window, and every later one, runs two average
// divisions and the ratio division on one shared bit-serial divider; when
// the average loss is zero the ratio division is skipped.
// The next price is taken once the block is back in idle, even while the
// previous result still waits in the output register. The period register
// resets to 14 and may only be written while no request is in flight.
module rsi_wilder_stream import rsi_pkg::*; #(
	parameter int PRICE_BITS          = PRICE_BITS_DEF,
	parameter int EXTRA_FRACTION_BITS = EXTRA_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	rsi_in_if.sink   sample,
	rsi_out_if.source result,
	rsi_cfg_if.sink  cfg
);

	rsi_cmd_t cmd;
	rsi_sts_t sts;

	assign cfg.ready = 1'b1;

	rsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsi_dp #(
		.PRICE_BITS          (PRICE_BITS),
		.EXTRA_FRACTION_BITS (EXTRA_FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.price     (sample.price),
		.restart   (sample.restart),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.rsi_value (result.rsi_value),
		.ready_res (result.ready_res)
	);

	// a result that is not ready carries zero
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready_res |-> result.rsi_value == '0)
		else $error("rsi_value nonzero without ready_res");

	// the ratio never exceeds full scale
	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.rsi_value <= RSI_FULL_SCALE)
		else $error("rsi_value above full scale");

	// one request at a time: intake closes right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second request accepted while busy");

	// a divider write command only comes with divider completion
	a_div_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_write |-> sts.div_done)
		else $error("divider result written before done");

endmodule

### hw/rtl/rsi_div.sv
// rsi_div: restoring divider, one quotient bit per cycle, with a preloaded
// partial remainder. Depends on rsi_pkg only for the import convention.
`timescale 1ns / 1ps

module rsi_div import rsi_pkg::*; #(
	parameter int DEN_W  = 49,
	parameter int QMAX   = 48,
	parameter int STEP_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEN_W-1:0]  rem_init,
	input  logic [QMAX-1:0]   low_init,
	input  logic [DEN_W-1:0]  den,
	input  logic [STEP_W-1:0] steps,
	output logic [QMAX-1:0]   quotient,
	output logic              done
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QMAX-1:0]   low_q;
	logic [QMAX-1:0]   quo_q;
	logic [DEN_W:0]    trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, low_q[QMAX-1]};
		ge    = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			low_q <= low_init;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			low_q <= low_q << 1;
			quo_q <= {quo_q[QMAX-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

### hw/rtl/rsi_ctrl.sv
// rsi_ctrl: sequencer for one price request: state update, wilder products,
// the two average divisions and the final ratio. Depends on rsi_pkg.
`timescale 1ns / 1ps

module rsi_ctrl import rsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rsi_sts_t sts,
	output rsi_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	div_op_t     op_q, op_d;
	res_sel_t    res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SEED_GAIN;
			res_q   <= RES_ZERO;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		res_d       = res_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.op      = op_q;
		cmd.res_sel = res_q;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.first) begin
					res_d   = RES_ZERO;
					state_d = ST_FINISH;
				end else if (sts.seeding) begin
					if (sts.seed_full) begin
						op_d    = OP_SEED_GAIN;
						state_d = ST_DIV_GO;
					end else begin
						res_d   = RES_ZERO;
						state_d = ST_FINISH;
					end
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				op_d    = OP_WILD_GAIN;
				state_d = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_write = 1'b1;
					unique case (op_q) inside
						OP_SEED_GAIN: begin
							op_d    = OP_SEED_LOSS;
							state_d = ST_DIV_GO;
						end
						OP_WILD_GAIN: begin
							op_d    = OP_WILD_LOSS;
							state_d = ST_DIV_GO;
						end
						OP_SEED_LOSS, OP_WILD_LOSS: begin
							state_d = ST_CHECK;
						end
						OP_RATIO: begin
							res_d   = RES_RATIO;
							state_d = ST_FINISH;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CHECK: begin
				// zero loss (and zero gain too) reads as full scale
				if (sts.loss_zero) begin
					res_d   = RES_FULL;
					state_d = ST_FINISH;
				end else begin
					op_d    = OP_RATIO;
					state_d = ST_DIV_GO;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hw/rtl/rsi_dp.sv
// rsi_dp: series state, period register, wilder products, divider operand
// selection and the result register. Depends on rsi_pkg and rsi_div.
`timescale 1ns / 1ps

module rsi_dp import rsi_pkg::*; #(
	parameter int PRICE_BITS          = PRICE_BITS_DEF,
	parameter int EXTRA_FRACTION_BITS = EXTRA_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsi_cmd_t              cmd,
	output rsi_sts_t              sts,
	input  logic [PRICE_BITS-1:0] price,
	input  logic                  restart,
	input  logic                  cfg_valid,
	input  logic [PERIOD_W-1:0]   cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [RSI_W-1:0]      rsi_value,
	output logic                  ready_res
);

	// averages carry the extra fraction bits; seeding sums need 8 more bits
	localparam int QB     = PRICE_BITS + EXTRA_FRACTION_BITS;
	localparam int AVG_W  = PRICE_BITS + max_int(PERIOD_W, EXTRA_FRACTION_BITS);
	localparam int SUM_W  = PRICE_BITS + PERIOD_W;
	localparam int PROD_W = QB + PERIOD_W;
	localparam int NUM_W  = QB + CNT_W;
	localparam int DEN_W  = QB + 1;
	localparam int QMAX   = max_int(QB, RSI_W);
	localparam int HUND_W = QB + SCALE_W;
	localparam int RAT_W  = HUND_W + RSI_FRAC;
	localparam int STEP_W = $clog2(QMAX + 1);

	logic [PERIOD_W-1:0]   period_q;
	logic [PRICE_BITS-1:0] prev_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  have_q;
	logic [AVG_W-1:0]      avg_g_q;
	logic [AVG_W-1:0]      avg_l_q;
	logic                  out_valid_q;

	logic [PRICE_BITS-1:0] price_q;
	logic                  restart_q;
	logic [PERIOD_W-1:0]   p_q;
	logic [PRICE_BITS-1:0] gain_q;
	logic [PRICE_BITS-1:0] loss_q;
	logic [PROD_W-1:0]     prod_g_q;
	logic [PROD_W-1:0]     prod_l_q;
	logic [RSI_W-1:0]      rsi_q;
	logic                  rdy_q;

	logic [PRICE_BITS-1:0] gain;
	logic [PRICE_BITS-1:0] loss;
	logic [CNT_W-1:0]      cnt_inc;
	logic [PERIOD_W-1:0]   pm1;
	logic [PROD_W-1:0]     prod_g;
	logic [PROD_W-1:0]     prod_l;
	logic [NUM_W-1:0]      num;
	logic [HUND_W-1:0]     hund;
	logic [RAT_W-1:0]      rnum;
	logic [DEN_W-1:0]      div_rem;
	logic [QMAX-1:0]       div_low;
	logic [DEN_W-1:0]      div_den;
	logic [STEP_W-1:0]     div_steps;
	logic [QMAX-1:0]       quo;
	logic                  div_done;

	always_comb begin
		gain    = (price_q > prev_q) ? price_q - prev_q : '0;
		loss    = (prev_q > price_q) ? prev_q - price_q : '0;
		cnt_inc = cnt_q + 1'b1;
		pm1     = p_q - 1'b1;
		prod_g  = pm1 * avg_g_q[QB-1:0];
		prod_l  = pm1 * avg_l_q[QB-1:0];
		hund    = HUND_W'(avg_g_q[QB-1:0]) * HUND_W'(RSI_SCALE);
		rnum    = {hund, {RSI_FRAC{1'b0}}};
	end

	always_comb begin
		sts.first     = restart_q || !have_q;
		sts.seeding   = !cnt_q[CNT_W-1];
		sts.seed_full = (cnt_inc >= {1'b0, p_q});
		sts.loss_zero = (avg_l_q == '0);
		sts.div_done  = div_done;
		sts.out_free  = !out_valid_q || out_ready;
	end

	// divider operands; quotient of seed and wilder steps always fits QB bits
	always_comb begin
		num       = '0;
		div_rem   = '0;
		div_low   = '0;
		div_den   = '0;
		div_steps = STEP_W'(QB);
		unique case (cmd.op)
			OP_SEED_GAIN: begin
				num     = NUM_W'(avg_g_q[SUM_W-1:0]) << EXTRA_FRACTION_BITS;
				div_den = DEN_W'(cnt_q);
			end
			OP_SEED_LOSS: begin
				num     = NUM_W'(avg_l_q[SUM_W-1:0]) << EXTRA_FRACTION_BITS;
				div_den = DEN_W'(cnt_q);
			end
			OP_WILD_GAIN: begin
				num     = NUM_W'(prod_g_q) + (NUM_W'(gain_q) << EXTRA_FRACTION_BITS);
				div_den = DEN_W'(p_q);
			end
			OP_WILD_LOSS: begin
				num     = NUM_W'(prod_l_q) + (NUM_W'(loss_q) << EXTRA_FRACTION_BITS);
				div_den = DEN_W'(p_q);
			end
			OP_RATIO: begin
				div_den = DEN_W'({1'b0, avg_g_q[QB-1:0]}) + DEN_W'({1'b0, avg_l_q[QB-1:0]});
			end
			default: begin
				div_den = '0;
			end
		endcase
		if (cmd.op == OP_RATIO) begin
			// quotient is below 2^RSI_W, so the upper part is below the divisor
			div_rem   = DEN_W'(rnum >> RSI_W);
			div_low   = QMAX'(rnum[RSI_W-1:0]) << (QMAX - RSI_W);
			div_steps = STEP_W'(RSI_W);
		end else begin
			div_rem   = DEN_W'(num >> QB);
			div_low   = QMAX'(num[QB-1:0]) << (QMAX - QB);
		end
	end

	rsi_div #(
		.DEN_W  (DEN_W),
		.QMAX   (QMAX),
		.STEP_W (STEP_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (div_rem),
		.low_init (div_low),
		.den      (div_den),
		.steps    (div_steps),
		.quotient (quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			prev_q      <= '0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			avg_g_q     <= '0;
			avg_l_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (cmd.eval) begin
				prev_q <= price_q;
				if (sts.first) begin
					cnt_q   <= '0;
					avg_g_q <= '0;
					avg_l_q <= '0;
					have_q  <= 1'b1;
				end else if (sts.seeding) begin
					avg_g_q <= avg_g_q + AVG_W'(gain);
					avg_l_q <= avg_l_q + AVG_W'(loss);
					cnt_q   <= cnt_inc;
				end
			end
			if (cmd.div_write) begin
				case (cmd.op) inside
					OP_SEED_GAIN, OP_WILD_GAIN: avg_g_q <= AVG_W'(quo[QB-1:0]);
					OP_SEED_LOSS: begin
						avg_l_q <= AVG_W'(quo[QB-1:0]);
						cnt_q   <= SMOOTH_MARK;
					end
					OP_WILD_LOSS: avg_l_q <= AVG_W'(quo[QB-1:0]);
					default: ;
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			price_q   <= price;
			restart_q <= restart;
			// period zero acts as period one
			p_q       <= (period_q == '0) ? PERIOD_W'(1) : period_q;
		end
		if (cmd.eval) begin
			gain_q <= gain;
			loss_q <= loss;
		end
		if (cmd.mul) begin
			prod_g_q <= prod_g;
			prod_l_q <= prod_l;
		end
		if (cmd.load_out) begin
			unique case (cmd.res_sel)
				RES_FULL: begin
					rsi_q <= RSI_FULL_SCALE;
					rdy_q <= 1'b1;
				end
				RES_RATIO: begin
					rsi_q <= quo[RSI_W-1:0];
					rdy_q <= 1'b1;
				end
				default: begin
					rsi_q <= '0;
					rdy_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign rsi_value = rsi_q;
	assign ready_res = rdy_q;

endmodule

### tb/sv/rsi_wilder_stream_test.sv
// rsi_wilder_stream_test: self-checking bench for the streaming Wilder RSI block.
// A directed table, then random price walks over several periods, checked against
// an in-bench predictor or pinned values. Depends on rsi_pkg, rsi_if, block RTL.
`timescale 1ns / 1ps

module rsi_wilder_stream_test;
	import rsi_pkg::*;

	localparam int EXTRA          = EXTRA_BITS_DEF;
	localparam int HOLD_CYCLES    = 800;
	localparam int STUCK_LIMIT    = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 300;
	localparam int MAX_REPORTS    = 100;
	localparam int N_ROWS         = 26;
	localparam logic [RSI_W-1:0] RSI_HALF_SCALE = RSI_FULL_SCALE >> 1;

	typedef struct packed {
		logic [RSI_W-1:0] value;
		logic             ready;
	} rsi_out_t;

	typedef enum logic {ROW_PRICE, ROW_PERIOD} row_kind_t;

	// for period rows the new period sits in the low byte of price
	typedef struct packed {
		row_kind_t        kind;
		logic [31:0]      price;
		logic             restart;
		logic             pinned;
		logic [RSI_W-1:0] rsi;
		logic             rdy;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsi_in_if #(.PRICE_BITS(PRICE_BITS_DEF)) price_ch ();
	rsi_out_if rsi_ch ();
	rsi_cfg_if period_ch ();

	rsi_wilder_stream uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (price_ch),
		.result (rsi_ch),
		.cfg    (period_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [PERIOD_W-1:0] period_len = PERIOD_RESET;
	logic [31:0]         last_price = '0;
	logic [CNT_W-1:0]    diff_count = '0;
	logic [63:0]         avg_gain = '0;
	logic [63:0]         avg_loss = '0;
	bit                  have_price = 1'b0;

	rsi_out_t rsi_expect_q[$];
	int       error_count = 0;
	int       stuck_cycles = 0;
	int       items_sent = 0;
	bit       sender_calm = 1'b0;

	row_t directed_rows [N_ROWS] = '{
		'{ROW_PRICE,  32'h0001_0000, 1'b0, 1'b1, 23'd0, 1'b0},    // first after reset
		'{ROW_PRICE,  32'h0002_0000, 1'b0, 1'b1, 23'd0, 1'b0},
		'{ROW_PERIOD, 32'd2,         1'b0, 1'b0, 23'd0, 1'b0},    // shrink while seeding
		'{ROW_PRICE,  32'h0003_0000, 1'b0, 1'b1, RSI_FULL_SCALE, 1'b1},
		'{ROW_PRICE,  32'h0001_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'hFFFF_FFFF, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0000_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0000_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h1234_5678, 1'b1, 1'b1, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h1234_5678, 1'b0, 1'b1, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h1234_5678, 1'b0, 1'b1, RSI_FULL_SCALE, 1'b1}, // both zero
		'{ROW_PERIOD, 32'd255,       1'b0, 1'b0, 23'd0, 1'b0},    // grow while smoothing
		'{ROW_PRICE,  32'h0000_0000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'hFFFF_FFFF, 1'b1, 1'b1, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0000_0000, 1'b0, 1'b1, 23'd0, 1'b0},
		'{ROW_PERIOD, 32'd1,         1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'hFFFF_FFFF, 1'b0, 1'b1, RSI_HALF_SCALE, 1'b1}, // mean of two
		'{ROW_PRICE,  32'h8000_0000, 1'b0, 1'b1, 23'd0, 1'b1},
		'{ROW_PERIOD, 32'd0,         1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h8000_0001, 1'b0, 1'b1, RSI_FULL_SCALE, 1'b1},
		'{ROW_PRICE,  32'h0000_0001, 1'b0, 1'b1, 23'd0, 1'b1},
		'{ROW_PERIOD, 32'd14,        1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0000_FFFF, 1'b1, 1'b1, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0001_8000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0000_4000, 1'b0, 1'b0, 23'd0, 1'b0},
		'{ROW_PRICE,  32'h0002_0000, 1'b0, 1'b0, 23'd0, 1'b0}
	};

	function automatic rsi_out_t predict_rsi(input logic [31:0] px, input logic restart);
		rsi_out_t     res;
		logic [63:0]  p;
		logic [63:0]  gain;
		logic [63:0]  loss;
		logic [127:0] ratio;
		bit           seeded;
		res = '0;
		seeded = 1'b0;
		p = (period_len == '0) ? 64'd1 : 64'(period_len);
		if (restart || !have_price) begin
			last_price = px;
			diff_count = '0;
			avg_gain = '0;
			avg_loss = '0;
			have_price = 1'b1;
			return res;
		end
		gain = (px > last_price) ? 64'(px - last_price) : 64'd0;
		loss = (last_price > px) ? 64'(last_price - px) : 64'd0;
		last_price = px;
		if (diff_count < SMOOTH_MARK) begin
			// raw sums until the window fills, then the mean with extra fraction bits
			avg_gain += gain;
			avg_loss += loss;
			diff_count++;
			if (64'(diff_count) >= p) begin
				avg_gain = (avg_gain << EXTRA) / 64'(diff_count);
				avg_loss = (avg_loss << EXTRA) / 64'(diff_count);
				diff_count = SMOOTH_MARK;
				seeded = 1'b1;
			end
		end else begin
			avg_gain = ((p - 64'd1) * avg_gain + (gain << EXTRA)) / p;
			avg_loss = ((p - 64'd1) * avg_loss + (loss << EXTRA)) / p;
			seeded = 1'b1;
		end
		if (seeded) begin
			res.ready = 1'b1;
			if (avg_loss == '0) begin
				res.value = RSI_FULL_SCALE;
			end else begin
				ratio = (128'(avg_gain) * 128'(RSI_FULL_SCALE)) / 128'(avg_gain + avg_loss);
				res.value = ratio[RSI_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic offer_price(input logic [31:0] px, input logic restart,
			input logic pinned, input logic [RSI_W-1:0] pin_value, input logic pin_ready);
		int unsigned gap;
		rsi_out_t    predicted;
		if (items_sent % 50 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
		items_sent++;
		gap = sender_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		price_ch.valid <= 1'b1;
		price_ch.price <= px;
		price_ch.restart <= restart;
		do @(posedge clk); while (price_ch.ready !== 1'b1);
		predicted = predict_rsi(px, restart);
		if (pinned) begin
			predicted.value = pin_value;
			predicted.ready = pin_ready;
		end
		rsi_expect_q = {rsi_expect_q, predicted};
	endtask

	// only with nothing in flight
	task automatic write_period(input logic [PERIOD_W-1:0] value);
		price_ch.valid <= 1'b0;
		while (rsi_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		period_ch.valid <= 1'b1;
		period_ch.data <= value;
		do @(posedge clk); while (period_ch.ready !== 1'b1);
		period_ch.valid <= 1'b0;
		period_len = value;
	endtask

	initial begin
		logic [31:0] walk;
		logic [31:0] delta;
		logic        rst_bit;
		int unsigned per;
		int unsigned n_items;
		int unsigned pick;
		price_ch.valid <= 1'b0;
		price_ch.price <= '0;
		price_ch.restart <= 1'b0;
		period_ch.valid <= 1'b0;
		period_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_PERIOD)
				write_period(directed_rows[i].price[PERIOD_W-1:0]);
			else
				offer_price(directed_rows[i].price, directed_rows[i].restart,
					directed_rows[i].pinned, directed_rows[i].rsi, directed_rows[i].rdy);
		end

		// random walks: mostly small moves so series get through seeding
		walk = 32'h0064_0000;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: per = 2;
				1: per = 255;
				2: per = 1;
				3: per = 0;
				4: per = 14;
				default: per = $urandom_range(2, 40);
			endcase
			write_period(per[PERIOD_W-1:0]);
			n_items = (per == 255) ? 300 : 160;
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					walk = $urandom;
				end else if (pick > 1) begin
					delta = $urandom_range(0, 32'd1 << $urandom_range(0, 20));
					if ($urandom_range(0, 1) == 1)
						walk = walk + delta;
					else
						walk = walk - delta;
				end
				rst_bit = ($urandom_range(0, 4 * per + 20) == 0);
				offer_price(walk, rst_bit, 1'b0, '0, 1'b0);
			end
		end

		price_ch.valid <= 1'b0;
		while (rsi_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls, calm stretches, and two long hold-offs
	initial begin
		int unsigned stall;
		int unsigned taken;
		bit          calm;
		rsi_out_t    want;
		taken = 0;
		calm = 1'b0;
		rsi_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// hold off results so the block fills and stalls price requests
			if (taken == 300 || taken == 900)
				stall = HOLD_CYCLES;
			else
				stall = calm ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				rsi_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsi_ch.ready <= 1'b1;
			do @(posedge clk); while (rsi_ch.valid !== 1'b1);
			taken++;
			if (rsi_expect_q.size() == 0) begin
				flag_error($sformatf("result with nothing pending: rsi %0d ready %0b",
					rsi_ch.rsi_value, rsi_ch.ready_res));
			end else begin
				want = rsi_expect_q.pop_front();
				if (rsi_ch.rsi_value !== want.value)
					flag_error($sformatf("result %0d: rsi_value %0d, expected %0d",
						taken, rsi_ch.rsi_value, want.value));
				if (rsi_ch.ready_res !== want.ready)
					flag_error($sformatf("result %0d: ready_res %0b, expected %0b",
						taken, rsi_ch.ready_res, want.ready));
			end
		end
	end

	// watchdog on cycles with no request moving on any channel
	always @(posedge clk) begin
		if ((price_ch.valid && price_ch.ready) || (rsi_ch.valid && rsi_ch.ready)
				|| (period_ch.valid && period_ch.ready) || !arst_n) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

### rsi_wilder_stream.f
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_if.sv
hw/rtl/rsi_div.sv
hw/rtl/rsi_ctrl.sv
hw/rtl/rsi_dp.sv
hw/rtl/rsi_wilder_stream.sv
tb/sv/rsi_wilder_stream_test.sv
